// ===== src/jkve_pkg.sv =====
// ----------------------------------------------------------------------------
// jkve_pkg
// Shared types and constants for the key/value extractor: result kinds,
// scan phases, result words, result bundles and the configuration group.
// ----------------------------------------------------------------------------
package jkve_pkg;

    localparam int          MAX_RESULTS        = 3;
    localparam int          QUEUE_DEPTH        = 4;
    localparam int          ADDR_W             = 5;
    localparam int          DATA_W             = 64;
    localparam logic [7:0]  COLON_CHAR         = 8'h3A;
    localparam logic [7:0]  COMMA_CHAR         = 8'h2C;
    localparam logic [7:0]  QUOTE_CHAR         = 8'h22;
    localparam logic [7:0]  COLON_WINDOW_RESET = 8'd50;
    localparam logic [3:0]  KEY_LENGTH_RESET   = 4'd8;

    typedef enum logic [1:0]
    {
        KIND_BYTE     = 2'd0,
        KIND_END      = 2'd1,
        KIND_NOCOLON  = 2'd2,
        KIND_TEXT_END = 2'd3
    } result_kind_t;

    typedef enum logic [1:0]
    {
        PH_SCAN    = 2'd0,
        PH_SEEK    = 2'd1,
        PH_CAPTURE = 2'd2
    } phase_t;

    typedef enum logic [1:0]
    {
        REG_KEY_TEXT     = 2'd0,
        REG_KEY_LENGTH   = 2'd1,
        REG_COLON_WINDOW = 2'd2
    } reg_index_t;

    typedef struct packed
    {
        result_kind_t kind;
        logic [7:0]   value_byte;
        logic [15:0]  occurrence;
        logic         truncated;
        logic [15:0]  occurrence_total;
        logic         is_last;
    } result_rec_t;

    typedef struct packed
    {
        logic [1:0]                         count;
        result_rec_t [MAX_RESULTS-1:0]      recs;
    } result_bundle_t;

    typedef struct packed
    {
        logic [63:0] key_text;
        logic [3:0]  key_length;
        logic [7:0]  colon_window;
    } cfg_t;

    function automatic result_rec_t make_rec(result_kind_t kind, logic [7:0] value_byte,
                                             logic [15:0] occurrence, logic truncated,
                                             logic [15:0] occurrence_total);
        result_rec_t r;
        r.kind             = kind;
        r.value_byte       = value_byte;
        r.occurrence       = occurrence;
        r.truncated        = truncated;
        r.occurrence_total = occurrence_total;
        r.is_last          = (kind == KIND_TEXT_END);
        return r;
    endfunction

endpackage

// ===== src/json_key_value_extractor_core.sv =====
// ----------------------------------------------------------------------------
// json_key_value_extractor_core
// Streaming key/value extractor. The front takes one text byte per cycle
// whenever full is low, matches the configured key, seeks the colon and
// classifies value bytes; each byte yields zero to three result words, which
// wait as one bundle in a four-entry queue. The back drains that queue and
// presents one result word per cycle while pop is high. Input runs at one
// byte per cycle as long as results average at most one per byte; bursts of
// more are absorbed by the queue, and the sustained limit is then the back's
// one word per cycle. Write the registers only while no text is in flight.
// ----------------------------------------------------------------------------
module json_key_value_extractor_core #(
    parameter int KEY_MAX   = 8,
    parameter int VALUE_MAX = 49
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [jkve_pkg::ADDR_W-1:0] paddr,
    input  logic [jkve_pkg::DATA_W-1:0] pwdata,
    output logic [jkve_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    input  logic                        push,
    output logic                        full,
    input  logic [7:0]                  text_byte,
    input  logic                        last_in_text,
    output logic                        empty,
    input  logic                        pop,
    output logic [1:0]                  result_kind,
    output logic [7:0]                  value_byte,
    output logic [15:0]                 occurrence,
    output logic                        truncated,
    output logic [15:0]                 occurrence_total,
    output logic                        is_last
);
    import jkve_pkg::*;

    cfg_t           cfg_reg, cfg_next;
    reg_index_t     reg_sel;
    logic           wr_hit;
    logic           q_push, q_full, q_pop, q_empty;
    result_bundle_t q_wr_data, q_rd_data;
    result_rec_t    word;

    assign pready  = 1'b1;
    assign reg_sel = reg_index_t'(paddr[4:3]);
    assign wr_hit  = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_hit)
        begin
            case (reg_sel)
                REG_KEY_TEXT:     cfg_next.key_text     = pwdata;
                REG_KEY_LENGTH:   cfg_next.key_length   = pwdata[3:0];
                REG_COLON_WINDOW: cfg_next.colon_window = pwdata[7:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_KEY_TEXT:     prdata = cfg_reg.key_text;
            REG_KEY_LENGTH:   prdata = {60'd0, cfg_reg.key_length};
            REG_COLON_WINDOW: prdata = {56'd0, cfg_reg.colon_window};
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.key_text     <= 64'd0;
            cfg_reg.key_length   <= KEY_LENGTH_RESET;
            cfg_reg.colon_window <= COLON_WINDOW_RESET;
        end
        else
            cfg_reg <= cfg_next;
    end

    jkve_front #(
        .KEY_MAX   (KEY_MAX),
        .VALUE_MAX (VALUE_MAX)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .push         (push),
        .full         (full),
        .text_byte    (text_byte),
        .last_in_text (last_in_text),
        .q_push       (q_push),
        .q_data       (q_wr_data),
        .q_full       (q_full)
    );

    jkve_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wr_data),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .rd_data (q_rd_data),
        .q_empty (q_empty)
    );

    jkve_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_data (q_rd_data),
        .q_empty (q_empty),
        .rd_en   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .word    (word)
    );

    assign result_kind      = word.kind;
    assign value_byte       = word.value_byte;
    assign occurrence       = word.occurrence;
    assign truncated        = word.truncated;
    assign occurrence_total = word.occurrence_total;
    assign is_last          = word.is_last;

endmodule

// ===== src/jkve_front.sv =====
// ----------------------------------------------------------------------------
// jkve_front
// Accepts text bytes, tracks the key window and the occurrence phase, and
// turns each byte into a bundle of zero to three result words.
// ----------------------------------------------------------------------------
module jkve_front #(
    parameter int KEY_MAX   = 8,
    parameter int VALUE_MAX = 49
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  jkve_pkg::cfg_t           cfg,
    input  logic                     push,
    output logic                     full,
    input  logic [7:0]               text_byte,
    input  logic                     last_in_text,
    output logic                     q_push,
    output jkve_pkg::result_bundle_t q_data,
    input  logic                     q_full
);
    import jkve_pkg::*;

    localparam int         KW        = 8 * KEY_MAX;
    localparam int         VL_W      = $clog2(VALUE_MAX + 1);
    localparam logic [3:0] KEY_MAX_L = 4'(KEY_MAX);

    logic [KW-1:0]   window_reg, window_next, window_step, shifted;
    logic [3:0]      fill_reg, fill_next, fill_inc;
    phase_t          phase_reg, phase_next, phase_step;
    logic [7:0]      cd_reg, cd_next;
    logic            quote_reg, quote_next;
    logic [VL_W-1:0] vlen_reg, vlen_next;
    logic [15:0]     cnt_reg, cnt_next;
    logic            cut_reg, cut_next;
    logic [15:0]     open_reg, open_next;

    logic [3:0]      eff_len;
    logic [6:0]      shamt;
    logic            colon_in_key, mismatch, match, wide_window, done;
    logic            accept;
    result_bundle_t  bundle;

    assign accept      = push && !q_full;
    assign full        = q_full;
    assign window_step = KW'({text_byte, window_reg} >> 8);
    assign fill_inc    = (fill_reg == KEY_MAX_L) ? fill_reg : fill_reg + 4'd1;
    assign eff_len     = (cfg.key_length > KEY_MAX_L) ? KEY_MAX_L : cfg.key_length;
    assign shamt       = {KEY_MAX_L - eff_len, 3'b000};
    assign shifted     = window_step >> shamt;
    assign wide_window = cfg.colon_window > {4'd0, eff_len};

    always_comb
    begin
        colon_in_key = 1'b0;
        mismatch     = 1'b0;
        for (int i = 0; i < KEY_MAX; i++)
        begin
            if (4'(i) < eff_len)
            begin
                if (cfg.key_text[8*i +: 8] == COLON_CHAR)
                    colon_in_key = 1'b1;
                if (shifted[8*i +: 8] != cfg.key_text[8*i +: 8])
                    mismatch = 1'b1;
            end
        end
    end

    assign match = (eff_len != 4'd0) && (fill_inc >= eff_len) && !colon_in_key && !mismatch;
    assign done  = ((text_byte == QUOTE_CHAR) && quote_reg) || (text_byte == COMMA_CHAR);

    // next phase
    always_comb
    begin
        phase_step = phase_reg;
        case (phase_reg)
            PH_SCAN:
            begin
                if (match && wide_window)
                    phase_step = PH_SEEK;
            end
            PH_SEEK:
            begin
                if (text_byte == COLON_CHAR)
                    phase_step = PH_CAPTURE;
                else if (cd_reg <= 8'd1)
                    phase_step = PH_SCAN;
            end
            PH_CAPTURE:
            begin
                if (done)
                    phase_step = PH_SCAN;
            end
            default:
            begin
                phase_step = PH_SCAN;
            end
        endcase
        phase_next = last_in_text ? PH_SCAN : phase_step;
    end

    // data state and result words
    always_comb
    begin
        logic [1:0] n;
        n           = 2'd0;
        bundle      = '0;
        window_next = window_step;
        fill_next   = fill_inc;
        cd_next     = cd_reg;
        quote_next  = quote_reg;
        vlen_next   = vlen_reg;
        cnt_next    = cnt_reg;
        cut_next    = cut_reg;
        open_next   = open_reg;
        case (phase_reg)
            PH_SCAN:
            begin
                if (match)
                begin
                    open_next = cnt_reg;
                    if (cnt_reg != 16'hFFFF)
                        cnt_next = cnt_reg + 16'd1;
                    if (wide_window)
                        cd_next = cfg.colon_window - {4'd0, eff_len};
                    else
                    begin
                        bundle.recs[n] = make_rec(KIND_NOCOLON, 8'd0, cnt_reg, 1'b0, 16'd0);
                        n = n + 2'd1;
                        fill_next = 4'd0;
                    end
                end
            end
            PH_SEEK:
            begin
                if (text_byte == COLON_CHAR)
                begin
                    quote_next = 1'b0;
                    vlen_next  = '0;
                    cut_next   = 1'b0;
                end
                else if (cd_reg <= 8'd1)
                begin
                    cd_next = 8'd0;
                    bundle.recs[n] = make_rec(KIND_NOCOLON, 8'd0, open_reg, 1'b0, 16'd0);
                    n = n + 2'd1;
                    fill_next = 4'd0;
                end
                else
                    cd_next = cd_reg - 8'd1;
            end
            PH_CAPTURE:
            begin
                if (text_byte == QUOTE_CHAR)
                begin
                    if (!quote_reg)
                        quote_next = 1'b1;
                end
                else if (text_byte != COMMA_CHAR)
                begin
                    if (vlen_reg < VL_W'(VALUE_MAX))
                    begin
                        bundle.recs[n] = make_rec(KIND_BYTE, text_byte, open_reg, 1'b0, 16'd0);
                        n = n + 2'd1;
                        vlen_next = vlen_reg + 1'b1;
                    end
                    else
                        cut_next = 1'b1;
                end
                if (done)
                begin
                    bundle.recs[n] = make_rec(KIND_END, 8'd0, open_reg, cut_reg, 16'd0);
                    n = n + 2'd1;
                    fill_next = 4'd0;
                end
            end
            default:
            begin
                fill_next = 4'd0;
            end
        endcase
        if (last_in_text)
        begin
            if (phase_step == PH_CAPTURE)
            begin
                bundle.recs[n] = make_rec(KIND_END, 8'd0, open_next, cut_next, 16'd0);
                n = n + 2'd1;
            end
            else if (phase_step == PH_SEEK)
            begin
                bundle.recs[n] = make_rec(KIND_NOCOLON, 8'd0, open_next, 1'b0, 16'd0);
                n = n + 2'd1;
            end
            bundle.recs[n] = make_rec(KIND_TEXT_END, 8'd0, 16'd0, 1'b0, cnt_next);
            n = n + 2'd1;
            window_next = '0;
            fill_next   = 4'd0;
            cd_next     = 8'd0;
            quote_next  = 1'b0;
            vlen_next   = '0;
            cnt_next    = 16'd0;
            cut_next    = 1'b0;
            open_next   = 16'd0;
        end
        bundle.count = n;
    end

    assign q_push = accept && (bundle.count != 2'd0);
    assign q_data = bundle;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            fill_reg   <= 4'd0;
            phase_reg  <= PH_SCAN;
            cd_reg     <= 8'd0;
            quote_reg  <= 1'b0;
            vlen_reg   <= '0;
            cnt_reg    <= 16'd0;
            cut_reg    <= 1'b0;
            open_reg   <= 16'd0;
        end
        else if (accept)
        begin
            window_reg <= window_next;
            fill_reg   <= fill_next;
            phase_reg  <= phase_next;
            cd_reg     <= cd_next;
            quote_reg  <= quote_next;
            vlen_reg   <= vlen_next;
            cnt_reg    <= cnt_next;
            cut_reg    <= cut_next;
            open_reg   <= open_next;
        end
    end

endmodule

// ===== src/jkve_queue.sv =====
// ----------------------------------------------------------------------------
// jkve_queue
// Short queue of result bundles between the classifying front and the
// draining back.
// ----------------------------------------------------------------------------
module jkve_queue (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     wr_en,
    input  jkve_pkg::result_bundle_t wr_data,
    output logic                     q_full,
    input  logic                     rd_en,
    output jkve_pkg::result_bundle_t rd_data,
    output logic                     q_empty
);
    import jkve_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    result_bundle_t   mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   cnt_reg, cnt_next;
    logic             do_wr, do_rd;

    assign q_full  = (cnt_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign q_empty = (cnt_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr && !do_rd)
            cnt_next = cnt_reg + 1'b1;
        else if (do_rd && !do_wr)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ===== src/jkve_back.sv =====
// ----------------------------------------------------------------------------
// jkve_back
// Takes result bundles from the queue and hands out their words one at a
// time from an output register.
// ----------------------------------------------------------------------------
module jkve_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  jkve_pkg::result_bundle_t rd_data,
    input  logic                     q_empty,
    output logic                     rd_en,
    output logic                     empty,
    input  logic                     pop,
    output jkve_pkg::result_rec_t    word
);
    import jkve_pkg::*;

    result_bundle_t cur_reg, cur_next;
    logic           valid_reg, valid_next;
    logic [1:0]     slot_reg, slot_next;
    logic           take, finishing, load;

    assign empty     = !valid_reg;
    assign take      = valid_reg && pop;
    assign finishing = take && (slot_reg == cur_reg.count - 2'd1);
    assign load      = !q_empty && (!valid_reg || finishing);
    assign rd_en     = load;
    assign word      = cur_reg.recs[slot_reg];

    always_comb
    begin
        cur_next   = cur_reg;
        valid_next = valid_reg;
        slot_next  = slot_reg;
        if (load)
        begin
            cur_next   = rd_data;
            valid_next = 1'b1;
            slot_next  = 2'd0;
        end
        else if (finishing)
            valid_next = 1'b0;
        else if (take)
            slot_next = slot_reg + 2'd1;
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            slot_reg  <= 2'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            slot_reg  <= slot_next;
        end
    end

endmodule

// ===== sim/jkve_result_checker.sv =====
// ----------------------------------------------------------------------------
// jkve_result_checker
// Watches the register port, the text side and the result side of the key/value
// extractor. Keeps its own copy of the registers and of the per-text scan state,
// works out the result words each accepted text byte must produce, and compares
// every popped word field by field against the oldest one still owed.
// ----------------------------------------------------------------------------
module jkve_result_checker #(
    parameter int KEY_MAX   = 8,
    parameter int VALUE_MAX = 49
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic                        pready,
    input  logic [jkve_pkg::ADDR_W-1:0] paddr,
    input  logic [jkve_pkg::DATA_W-1:0] pwdata,
    input  logic                        push,
    input  logic                        full,
    input  logic [7:0]                  text_byte,
    input  logic                        last_in_text,
    input  logic                        pop,
    input  logic                        empty,
    input  logic [1:0]                  result_kind,
    input  logic [7:0]                  value_byte,
    input  logic [15:0]                 occurrence,
    input  logic                        truncated,
    input  logic [15:0]                 occurrence_total,
    input  logic                        is_last,
    output int                          fail_count,
    output int                          pending,
    output int                          words_checked
);
    import jkve_pkg::*;

    localparam int ERROR_PRINT_MAX = 40;

    logic [63:0] cfg_key;
    logic [3:0]  cfg_len;
    logic [7:0]  cfg_window;

    logic [63:0] recent_bytes;
    int          fill;
    phase_t      scan_phase;
    logic [7:0]  colon_left;
    logic        quote_open;
    int          value_count;
    logic [15:0] occ_count;
    logic        cut;
    logic [15:0] open_occ;

    result_rec_t expected_words[$];
    result_rec_t head;

    task automatic clear_text_state();
        recent_bytes = '0;
        fill         = 0;
        scan_phase   = PH_SCAN;
        colon_left   = '0;
        quote_open   = 1'b0;
        value_count  = 0;
        occ_count    = '0;
        cut          = 1'b0;
        open_occ     = '0;
    endtask

    task automatic owe_word(input result_kind_t kind, input logic [7:0] b,
                            input logic [15:0] occ, input logic trunc,
                            input logic [15:0] total, input logic fin);
        result_rec_t w;
        w.kind             = kind;
        w.value_byte       = b;
        w.occurrence       = occ;
        w.truncated        = trunc;
        w.occurrence_total = total;
        w.is_last          = fin;
        expected_words.push_back(w);
    endtask

    task automatic extract_step(input logic [7:0] b, input logic fin);
        int   klen;
        int   i;
        logic hit;
        logic done;
        recent_bytes = {b, recent_bytes[63:8]};
        if (fill < 8)
            fill = fill + 1;
        case (scan_phase)
            PH_SCAN:
            begin
                klen = (cfg_len > KEY_MAX) ? KEY_MAX : int'(cfg_len);
                hit  = (klen != 0) && (fill >= klen);
                for (i = 0; i < KEY_MAX; i++)
                begin
                    if (i < klen)
                    begin
                        if (cfg_key[8*i +: 8] == COLON_CHAR)
                            hit = 1'b0;
                        if (recent_bytes[8*(8-klen+i) +: 8] != cfg_key[8*i +: 8])
                            hit = 1'b0;
                    end
                end
                if (hit)
                begin
                    open_occ = occ_count;
                    if (occ_count != 16'hFFFF)
                        occ_count = occ_count + 1;
                    if (cfg_window > klen)
                    begin
                        colon_left = cfg_window - 8'(klen);
                        scan_phase = PH_SEEK;
                    end
                    else
                    begin
                        owe_word(KIND_NOCOLON, 8'h00, open_occ, 1'b0, 16'h0, 1'b0);
                        fill = 0;
                    end
                end
            end
            PH_SEEK:
            begin
                if (b == COLON_CHAR)
                begin
                    scan_phase  = PH_CAPTURE;
                    quote_open  = 1'b0;
                    value_count = 0;
                    cut         = 1'b0;
                end
                else if (colon_left <= 1)
                begin
                    colon_left = '0;
                    owe_word(KIND_NOCOLON, 8'h00, open_occ, 1'b0, 16'h0, 1'b0);
                    scan_phase = PH_SCAN;
                    fill       = 0;
                end
                else
                    colon_left = colon_left - 1;
            end
            default:
            begin
                done = 1'b0;
                if (b == QUOTE_CHAR)
                begin
                    if (quote_open)
                        done = 1'b1;
                    else
                        quote_open = 1'b1;
                end
                else if (b == COMMA_CHAR)
                    done = 1'b1;
                else if (value_count < VALUE_MAX)
                begin
                    owe_word(KIND_BYTE, b, open_occ, 1'b0, 16'h0, 1'b0);
                    value_count++;
                end
                else
                    cut = 1'b1;
                if (done)
                begin
                    owe_word(KIND_END, 8'h00, open_occ, cut, 16'h0, 1'b0);
                    scan_phase = PH_SCAN;
                    fill       = 0;
                end
            end
        endcase
        if (fin)
        begin
            if (scan_phase == PH_CAPTURE)
                owe_word(KIND_END, 8'h00, open_occ, cut, 16'h0, 1'b0);
            else if (scan_phase == PH_SEEK)
                owe_word(KIND_NOCOLON, 8'h00, open_occ, 1'b0, 16'h0, 1'b0);
            owe_word(KIND_TEXT_END, 8'h00, 16'h0, 1'b0, occ_count, 1'b1);
            clear_text_state();
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            fail_count++;
            if (fail_count <= ERROR_PRINT_MAX)
                $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_key    = '0;
            cfg_len    = KEY_LENGTH_RESET;
            cfg_window = COLON_WINDOW_RESET;
            clear_text_state();
            expected_words.delete();
            fail_count    = 0;
            pending       = 0;
            words_checked = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_words.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= ERROR_PRINT_MAX)
                        $error("result word with none expected: kind %0d", result_kind);
                end
                else
                begin
                    head = expected_words.pop_front();
                    check_field("result_kind", head.kind, result_kind);
                    check_field("value_byte", head.value_byte, value_byte);
                    check_field("occurrence", head.occurrence, occurrence);
                    check_field("truncated", head.truncated, truncated);
                    check_field("occurrence_total", head.occurrence_total, occurrence_total);
                    check_field("is_last", head.is_last, is_last);
                    words_checked++;
                end
            end
            if (psel && penable && pwrite && pready)
            begin
                case (reg_index_t'(paddr[4:3]))
                    REG_KEY_TEXT:     cfg_key    = pwdata;
                    REG_KEY_LENGTH:   cfg_len    = pwdata[3:0];
                    REG_COLON_WINDOW: cfg_window = pwdata[7:0];
                    default:          ;
                endcase
            end
            if (push && !full)
                extract_step(text_byte, last_in_text);
            pending = expected_words.size();
        end
    end

endmodule

// ===== sim/json_key_value_extractor_core_tb.sv =====
// ----------------------------------------------------------------------------
// json_key_value_extractor_core_tb
// Drives JSON-like text into the key/value extractor: a short directed set for
// overlapping keys, open searches and captures at text end, keys holding a
// colon, a zero key length and a too-short colon window; then random records,
// some without a colon or quotes, with noise under several register settings,
// one of them with an oversized key length. The checker grades results.
// ----------------------------------------------------------------------------
module json_key_value_extractor_core_tb;
    import jkve_pkg::*;

    localparam int KEY_MAX     = 8;
    localparam int VALUE_MAX   = 49;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE      = 12;
    localparam int PHASE_BYTES = 35;

    logic              clk;
    logic              rst_n        = 1'b0;
    logic              psel         = 1'b0;
    logic              penable      = 1'b0;
    logic              pwrite       = 1'b0;
    logic [ADDR_W-1:0] paddr        = '0;
    logic [DATA_W-1:0] pwdata       = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              push         = 1'b0;
    logic              full;
    logic [7:0]        text_byte    = 8'h00;
    logic              last_in_text = 1'b0;
    logic              empty;
    logic              pop          = 1'b0;
    logic [1:0]        result_kind;
    logic [7:0]        value_byte;
    logic [15:0]       occurrence;
    logic              truncated;
    logic [15:0]       occurrence_total;
    logic              is_last;

    int fail_count;
    int pending;
    int words_checked;

    bit         idle_on        = 1'b1;
    bit         drain_once     = 1'b0;
    int         pop_hold       = 0;
    int         cycle_count    = 0;
    int         bytes_sent     = 0;
    int         texts_sent     = 0;
    int         settings_used  = 0;
    logic [63:0] cur_key;
    logic [3:0]  cur_len;

    json_key_value_extractor_core #(
        .KEY_MAX   (KEY_MAX),
        .VALUE_MAX (VALUE_MAX)
    ) u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .push             (push),
        .full             (full),
        .text_byte        (text_byte),
        .last_in_text     (last_in_text),
        .empty            (empty),
        .pop              (pop),
        .result_kind      (result_kind),
        .value_byte       (value_byte),
        .occurrence       (occurrence),
        .truncated        (truncated),
        .occurrence_total (occurrence_total),
        .is_last          (is_last)
    );

    jkve_result_checker #(
        .KEY_MAX   (KEY_MAX),
        .VALUE_MAX (VALUE_MAX)
    ) u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .pready           (pready),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .push             (push),
        .full             (full),
        .text_byte        (text_byte),
        .last_in_text     (last_in_text),
        .pop              (pop),
        .empty            (empty),
        .result_kind      (result_kind),
        .value_byte       (value_byte),
        .occurrence       (occurrence),
        .truncated        (truncated),
        .occurrence_total (occurrence_total),
        .is_last          (is_last),
        .fail_count       (fail_count),
        .pending          (pending),
        .words_checked    (words_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (pop_hold > 0)
        begin
            pop      <= 1'b0;
            pop_hold <= pop_hold - 1;
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            pop      <= 1'b0;
            pop_hold <= $urandom_range(0, 5);
        end
        else
            pop <= 1'b1;
    end

    task automatic wait_idle();
        push <= 1'b0;
        repeat (2) @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [63:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input logic [63:0] key, input logic [3:0] len,
                              input logic [7:0] window);
        wait_idle();
        write_reg(REG_KEY_TEXT, key);
        write_reg(REG_KEY_LENGTH, {60'h0, len});
        write_reg(REG_COLON_WINDOW, {56'h0, window});
        cur_key = key;
        cur_len = len;
        settings_used++;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic fin);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        push         <= 1'b1;
        text_byte    <= b;
        last_in_text <= fin;
        do
            @(posedge clk);
        while (full);
        bytes_sent++;
    endtask

    task automatic send_text(ref logic [7:0] q[$]);
        int i;
        for (i = 0; i < q.size(); i++)
        begin
            if (drain_once && i == q.size() / 2)
            begin
                push <= 1'b0;
                repeat (2) @(posedge clk);
                while (pending != 0)
                    @(posedge clk);
                drain_once = 1'b0;
            end
            send_byte(q[i], i == q.size() - 1);
        end
        texts_sent++;
    endtask

    function automatic logic [63:0] pick_key(input bit any_byte);
        logic [63:0] key;
        logic [7:0]  b;
        int          i;
        for (i = 0; i < 8; i++)
        begin
            b = any_byte ? 8'($urandom_range(0, 255)) : 8'($urandom_range(8'h61, 8'h7A));
            if (b == COLON_CHAR)
                b = 8'h3B;
            key[8*i +: 8] = b;
        end
        return key;
    endfunction

    task automatic add_record(ref logic [7:0] q[$]);
        int klen;
        int vlen;
        int i;
        klen = (cur_len > KEY_MAX) ? KEY_MAX : int'(cur_len);
        repeat ($urandom_range(0, 3))
            q.push_back(8'($urandom_range(0, 255)));
        for (i = 0; i < klen; i++)
            q.push_back(cur_key[8*i +: 8]);
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(3, 14)) q.push_back(8'h20);
        else
            repeat ($urandom_range(0, 2)) q.push_back(8'h20);
        if ($urandom_range(0, 9) != 0)
            q.push_back(COLON_CHAR);
        if ($urandom_range(0, 3) != 0)
            q.push_back(QUOTE_CHAR);
        vlen = ($urandom_range(0, 4) == 0) ? $urandom_range(45, 60) : $urandom_range(0, 8);
        repeat (vlen)
        begin
            if ($urandom_range(0, 7) == 0)
                q.push_back(8'($urandom_range(0, 255)));
            else
                q.push_back(8'($urandom_range(8'h30, 8'h7A)));
        end
        case ($urandom_range(0, 3))
            0, 1:    q.push_back(QUOTE_CHAR);
            2:       q.push_back(COMMA_CHAR);
            default: ;
        endcase
    endtask

    task automatic random_text();
        logic [7:0] q[$];
        repeat ($urandom_range(1, 3))
            add_record(q);
        send_text(q);
    endtask

    task automatic random_phase(input int target);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < target)
            random_text();
    endtask

    initial
    begin
        logic [7:0] q[$];

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: overlap, comma end, open search and open capture at text end
        set_config(64'h6161, 4'd2, 8'd9);
        q = '{8'h61, 8'h61, 8'h61, COLON_CHAR, QUOTE_CHAR, 8'hFF, 8'h00, COMMA_CHAR,
              8'h61, 8'h61, 8'h78, 8'h78};
        send_text(q);
        q = '{8'h61, 8'h61, COLON_CHAR, 8'h76};
        send_text(q);

        // directed: window no larger than the key
        set_config(64'hFFFF_FFFF_FFFF_FFFF, 4'd2, 8'd0);
        q = '{8'hFF, 8'hFF, 8'hFF, 8'h00};
        send_text(q);

        // directed: key holding a colon, then a zero key length
        set_config({48'h0, COLON_CHAR, 8'h61}, 4'd2, 8'd9);
        q = '{8'h61, COLON_CHAR};
        send_text(q);
        set_config(64'h6161, 4'd0, 8'd9);
        q = '{8'h61, 8'h61};
        send_text(q);

        set_config(pick_key(1'b0), 4'd1, 8'd9);
        random_phase(PHASE_BYTES);

        set_config(pick_key(1'b1), 4'd8, 8'd255);
        drain_once = 1'b1;
        random_phase(PHASE_BYTES);

        idle_on = 1'b0;
        set_config(pick_key(1'b0), 4'd15, 8'($urandom_range(9, 40)));
        random_phase(PHASE_BYTES);

        set_config(pick_key(1'b0), 4'($urandom_range(1, 8)), 8'($urandom_range(9, 255)));
        random_phase(PHASE_BYTES);

        wait_idle();
        repeat (SETTLE) @(posedge clk);

        $display("Sent %0d text bytes in %0d texts under %0d register settings.",
                 bytes_sent, texts_sent, settings_used);
        $display("Compared %0d result words across directed and random texts.",
                 words_checked);
        if (fail_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
